// ===== rtl/core/pccrl_pkg.sv =====
package pccrl_pkg;

    localparam int NUM_CLIENTS_DEF = 64;

    localparam int OP_W      = 2;
    localparam int CLIENT_W  = 6;
    localparam int TIME_W    = 32;
    localparam int SECS_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int VERDICT_W = 3;
    localparam int REMAIN_W  = 17;
    localparam int COUNT_W   = 16;

    localparam logic [REMAIN_W-1:0] REMAIN_MAX = REMAIN_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_CHAT   = 2'd0,
        OP_TMUTE  = 2'd1,
        OP_PMUTE  = 2'd2,
        OP_UNMUTE = 2'd3
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_ALLOWED     = 3'd0,
        V_BLOCKED     = 3'd1,
        V_FLOOD_TMUTE = 3'd2,
        V_FLOOD_PMUTE = 3'd3,
        V_FLOOD_DISC  = 3'd4,
        V_ADMIN_DONE  = 3'd5
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOOD_ENABLE   = 2'd0,
        REG_MAX_MESSAGES   = 2'd1,
        REG_WINDOW_LENGTH  = 2'd2,
        REG_SILENCE_ACTION = 2'd3
    } cfg_reg_t;

    localparam int FLAG_TIMED = 0;
    localparam int FLAG_PERM  = 1;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [COUNT_W-1:0] count;
        logic [1:0]         flags;
    } client_entry_t;

endpackage

// ===== rtl/core/per_client_chat_rate_limiter_core.sv =====
// Pipeline: a word accepted into stage 1 moves on to the output register when that register is free or being read.
// Throughput: one word per cycle unless stalled by out_ready; the client table is read at accept and written
// when the word moves to the output register, with a bypass for back-to-back hits.
// Reset: config registers and per-client valid bits clear at once; an entry not
// yet written reads as zero. No clearing pass, so the block is ready right away.
module per_client_chat_rate_limiter_core #(
    parameter int NUM_CLIENTS = pccrl_pkg::NUM_CLIENTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pccrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pccrl_pkg::CFG_W-1:0]       cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pccrl_pkg::OP_W-1:0]        operation,
    input  logic [pccrl_pkg::CLIENT_W-1:0]    client_id,
    input  logic [pccrl_pkg::TIME_W-1:0]      now,
    input  logic [pccrl_pkg::SECS_W-1:0]      mute_seconds,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pccrl_pkg::VERDICT_W-1:0]   verdict,
    output logic [pccrl_pkg::REMAIN_W-1:0]    remaining_time
);
    import pccrl_pkg::*;

    localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

    // config
    logic                     flood_enable_reg;
    logic [CFG_W-1:0]         max_messages_reg;
    logic [CFG_W-1:0]         window_length_reg;
    logic signed [CFG_W-1:0]  silence_action_reg;

    // client table
    client_entry_t            table_mem [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0]   valid_bits_reg;

    // stage 1
    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    logic [IDX_W-1:0]         s1_addr_reg;
    logic                     s1_inr_reg;
    logic [TIME_W-1:0]        s1_now_reg;
    logic [SECS_W-1:0]        s1_secs_reg;
    client_entry_t            rd_data_reg;
    logic                     rd_valid_reg;

    // bypass of the last table write
    logic                     byp_valid_reg;
    logic [IDX_W-1:0]         byp_addr_reg;
    client_entry_t            byp_data_reg;

    // output
    logic                     out_valid_reg;
    verdict_t                 verdict_reg;
    logic [REMAIN_W-1:0]      remain_reg;

    logic                     in_fire;
    logic                     s1_fire;
    logic [IDX_W-1:0]         in_addr;
    logic                     in_range;
    logic                     do_write;

    client_entry_t            cur;
    client_entry_t            entry_next;
    verdict_t                 verdict_next;
    logic [REMAIN_W-1:0]      remain_next;
    logic                     expired;
    logic [TIME_W-1:0]        diff;
    logic [TIME_W-1:0]        addend;
    logic [TIME_W:0]          sum_wide;
    logic [TIME_W-1:0]        sat_sum;
    logic [1:0]               flags_mid;
    logic                     blocked;

    assign cfg_ready = 1'b1;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;
    assign in_addr  = IDX_W'(client_id);
    assign in_range = (32'(client_id) < NUM_CLIENTS);

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign remaining_time = remain_reg;

    // current entry: newest write wins over the registered read
    always_comb
    begin
        if (byp_valid_reg && byp_addr_reg == s1_addr_reg)
            cur = byp_data_reg;
        else if (rd_valid_reg)
            cur = rd_data_reg;
        else
            cur = '0;
    end

    assign expired = (cur.deadline < s1_now_reg);
    assign diff    = cur.deadline - s1_now_reg;

    // one saturating adder shared by all deadline updates
    always_comb
    begin
        if (s1_op_reg == OP_TMUTE)
            addend = TIME_W'(s1_secs_reg);
        else if (expired)
            addend = TIME_W'(window_length_reg);
        else
            addend = TIME_W'(unsigned'(silence_action_reg));
    end

    assign sum_wide = {1'b0, s1_now_reg} + {1'b0, addend};
    assign sat_sum  = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];

    always_comb
    begin
        entry_next   = cur;
        verdict_next = V_ALLOWED;
        remain_next  = '0;
        flags_mid    = cur.flags;
        blocked      = 1'b0;
        if (!s1_inr_reg) begin
            verdict_next = (s1_op_reg == OP_CHAT) ? V_ALLOWED : V_ADMIN_DONE;
        end else begin
            unique case (s1_op_reg)
                OP_TMUTE:
                begin
                    if (s1_secs_reg != '0) begin
                        entry_next.deadline = sat_sum;
                        entry_next.flags    = 2'b01;
                    end else begin
                        entry_next.flags = 2'b00;
                    end
                    verdict_next = V_ADMIN_DONE;
                end
                OP_PMUTE:
                begin
                    entry_next.flags[FLAG_PERM] = 1'b1;
                    verdict_next = V_ADMIN_DONE;
                end
                OP_UNMUTE:
                begin
                    entry_next.flags = 2'b00;
                    verdict_next = V_ADMIN_DONE;
                end
                OP_CHAT:
                begin
                    if (cur.flags[FLAG_PERM]) begin
                        blocked      = 1'b1;
                        verdict_next = V_BLOCKED;
                    end else if (cur.flags[FLAG_TIMED]) begin
                        if (expired) begin
                            flags_mid[FLAG_TIMED] = 1'b0;
                        end else begin
                            blocked      = 1'b1;
                            verdict_next = V_BLOCKED;
                            remain_next  = (diff >= TIME_W'(65535)) ? REMAIN_MAX
                                         : REMAIN_W'(diff + TIME_W'(1));
                        end
                    end
                    entry_next.flags = flags_mid;
                    if (!blocked && flood_enable_reg) begin
                        if (expired) begin
                            entry_next.deadline = sat_sum;
                            entry_next.count    = '0;
                        end else if (cur.count >= max_messages_reg) begin
                            if (silence_action_reg == '0) begin
                                verdict_next = V_FLOOD_DISC;
                            end else if (silence_action_reg[CFG_W-1]) begin
                                entry_next.flags[FLAG_PERM] = 1'b1;
                                verdict_next = V_FLOOD_PMUTE;
                            end else begin
                                entry_next.deadline          = sat_sum;
                                entry_next.flags[FLAG_TIMED] = 1'b1;
                                verdict_next = V_FLOOD_TMUTE;
                            end
                        end else begin
                            entry_next.count = COUNT_W'(cur.count + COUNT_W'(1));
                        end
                    end
                end
                default:
                begin
                    verdict_next = V_ALLOWED;
                end
            endcase
        end
    end

    assign do_write = s1_fire && s1_inr_reg;

    // table storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_write)
            table_mem[s1_addr_reg] <= entry_next;
        if (in_fire)
            rd_data_reg <= table_mem[in_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flood_enable_reg   <= 1'b0;
            max_messages_reg   <= '0;
            window_length_reg  <= '0;
            silence_action_reg <= '0;
            valid_bits_reg     <= '0;
            s1_valid_reg       <= 1'b0;
            byp_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            rd_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FLOOD_ENABLE:   flood_enable_reg   <= cfg_data[0];
                    REG_MAX_MESSAGES:   max_messages_reg   <= cfg_data;
                    REG_WINDOW_LENGTH:  window_length_reg  <= cfg_data;
                    REG_SILENCE_ACTION: silence_action_reg <= signed'(cfg_data);
                    default: ;
                endcase
            end
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= in_range ? valid_bits_reg[in_addr] : 1'b0;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (do_write) begin
                valid_bits_reg[s1_addr_reg] <= 1'b1;
                byp_valid_reg <= 1'b1;
            end
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_op_reg   <= op_t'(operation);
            s1_addr_reg <= in_addr;
            s1_inr_reg  <= in_range;
            s1_now_reg  <= now;
            s1_secs_reg <= mute_seconds;
        end
        if (do_write) begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= entry_next;
        end
        if (s1_fire) begin
            verdict_reg <= verdict_next;
            remain_reg  <= remain_next;
        end
    end

    a_admin_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_op_reg != OP_CHAT |=> verdict_reg == V_ADMIN_DONE)
        else $error("admin word did not report admin done");

    a_chat_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_op_reg == OP_CHAT |=> verdict_reg != V_ADMIN_DONE)
        else $error("chat word reported admin done");

    a_remain_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && remain_reg != '0 |-> verdict_reg == V_BLOCKED)
        else $error("time left reported without a mute block");

    a_remain_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> remain_reg <= REMAIN_MAX)
        else $error("time left beyond saturation");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

endmodule
